// File: sv/sem_pkg.sv
`timescale 1ns / 1ps
package sem_pkg;
	localparam int MaxWidth = 2048;
	localparam int MaxHeight = 2048;
	localparam int ColW = $clog2(MaxWidth);
	localparam int DimW = 12;
	localparam int CntW = 24;
	localparam int SqW = 17;
	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef logic [23:0] pix_t;

	// one channel's 3x3 neighborhood, already masked
	typedef struct packed {
		logic [2:0][2:0][7:0] g;
	} win_t;

	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v, input int mx);
		logic [DimW:0] m;
		m = (DimW+1)'(mx);
		if (v == '0) return DimW'(1);
		if ({1'b0, v} > m) return DimW'(mx);
		return v;
	endfunction
endpackage

// File: sv/sem_grad.sv
`timescale 1ns / 1ps
// One lane: Sobel gx/gy squared sum for one channel, registered.
module sem_grad (
	input  logic                   clk,
	input  logic                   en,
	input  sem_pkg::win_t          win,
	output logic [sem_pkg::SqW-1:0] mag2_s2
);
	logic signed [11:0] gx, gy;
	logic signed [11:0] gx_s1, gy_s1;
	logic [21:0] sx, sy;

	always_comb begin
		gx = 12'(signed'({4'b0, win.g[0][2]})) - 12'(signed'({4'b0, win.g[0][0]}))
			+ 12'(signed'({3'b0, win.g[1][2], 1'b0})) - 12'(signed'({3'b0, win.g[1][0], 1'b0}))
			+ 12'(signed'({4'b0, win.g[2][2]})) - 12'(signed'({4'b0, win.g[2][0]}));
		gy = 12'(signed'({4'b0, win.g[2][0]})) - 12'(signed'({4'b0, win.g[0][0]}))
			+ 12'(signed'({3'b0, win.g[2][1], 1'b0})) - 12'(signed'({3'b0, win.g[0][1], 1'b0}))
			+ 12'(signed'({4'b0, win.g[2][2]})) - 12'(signed'({4'b0, win.g[0][2]}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s1 <= gx;
			gy_s1 <= gy;
		end
	end

	assign sx = 22'(gx_s1 * gx_s1);
	assign sy = 22'(gy_s1 * gy_s1);

	logic [22:0] sum;
	assign sum = {1'b0, sx} + {1'b0, sy};

	// saturate: anything above 65280 rounds to 255 anyway
	always_ff @(posedge clk) begin
		if (en) mag2_s2 <= (sum > 23'd65535) ? '1 : sem_pkg::SqW'(sum);
	end
endmodule

// File: sv/sem_root.sv
`timescale 1ns / 1ps
// Rounded integer square root, one result bit per cycle.
module sem_root (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [sem_pkg::SqW-1:0] m,
	output logic                    busy,
	output logic                    done,
	output logic [7:0]              root
);
	logic [sem_pkg::SqW-1:0] m_q;
	logic [7:0] s_q, bit_q;
	logic [7:0] t;
	logic [16:0] tt, ss;

	assign t = s_q | bit_q;
	assign tt = 17'(t * t);
	assign ss = 17'(s_q * s_q) + 17'(s_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) busy <= 1'b1;
			else if (busy && bit_q == '0) begin
				busy <= 1'b0;
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= m;
			s_q <= '0;
			bit_q <= 8'h80;
		end else if (busy) begin
			if (bit_q != '0) begin
				if (tt <= m_q) s_q <= t;
				bit_q <= bit_q >> 1;
			end else begin
				if (m_q > 17'd65280) root <= 8'hFF;
				else if (m_q > ss) root <= s_q + 8'd1;
				else root <= s_q;
			end
		end
	end
endmodule

// File: sv/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order, zero outside the frame.
// Results lag input by frame_width+1 pixels; after the last pixel, send drain items
// (req_type=1) to flush the rest, one result per drain. An item that yields a result
// passes from its accept through these steps in order: row store write-back, gradient
// lanes, the bit-serial rounded square root (8 bit steps and a rounding step, three
// lanes in parallel), then loading the output register. No new item is taken before that.
// An item that yields no result goes from the row store write-back straight to the output
// stage; a dropped item is taken without leaving idle. A result still waiting
// in the output register holds the block in its output stage. Pixels during an
// unfinished drain and drains mid-frame are taken and dropped. A configuration write is
// taken only while no input item is offered and restarts the frame. Row stores are
// 2048-entry memories with no clearing; out-of-frame reads are masked.
module sobel_edge_magnitude_rgb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        frame_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_GRAD = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [sem_pkg::DimW-1:0] w_q, h_q;
	logic [sem_pkg::DimW-1:0] col_q, row_q;
	logic [sem_pkg::CntW-1:0] emitted_q, ocol_q;
	logic [sem_pkg::DimW-1:0] orow_q;
	sem_pkg::pix_t upper_mem [sem_pkg::MaxWidth];
	sem_pkg::pix_t middle_mem [sem_pkg::MaxWidth];
	sem_pkg::pix_t win_q [6];
	sem_pkg::pix_t up_rd_q, mid_rd_q, px_q;
	logic emit_q, last_q;

	logic [sem_pkg::CntW-1:0] total, n;
	logic in_acc, out_acc, cfg_acc, drain, take, emit;
	logic [sem_pkg::ColW-1:0] x;

	assign total = sem_pkg::CntW'(w_q * h_q);
	assign n = sem_pkg::CntW'(row_q * w_q) + sem_pkg::CntW'(col_q);
	assign in_ready = (state_q == ST_IDLE);
	// input transfers take priority over register writes
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;
	assign in_acc = in_valid && in_ready;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign out_acc = out_valid && out_ready;
	assign drain = req_type;
	assign take = drain ? (n >= total) : (n < total);
	assign emit = (n >= sem_pkg::CntW'(w_q) + 1'b1) && (emitted_q < total);
	assign x = col_q[sem_pkg::ColW-1:0];

	// row stores: read in accept cycle, write back the shifted column
	always_ff @(posedge clk) begin
		if (in_acc && take) begin
			up_rd_q <= upper_mem[x];
			mid_rd_q <= middle_mem[x];
		end
		if (state_q == ST_READ) begin
			upper_mem[x] <= mid_rd_q;
			middle_mem[x] <= px_q;
		end
		if (in_acc) px_q <= drain ? '0 : {in_red, in_green, in_blue};
	end

	// masked windows per lane
	logic vr0, vr2, vc0, vc2;
	sem_pkg::pix_t grid [3][3];
	sem_pkg::win_t lane_win [3];
	assign vr0 = orow_q != '0;
	assign vr2 = (orow_q + 1'b1) < h_q;
	assign vc0 = ocol_q != '0;
	assign vc2 = (ocol_q + 1'b1) < sem_pkg::CntW'(w_q);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			grid[r][0] = win_q[r];
			grid[r][1] = win_q[3+r];
		end
		grid[0][2] = up_rd_q;
		grid[1][2] = mid_rd_q;
		grid[2][2] = px_q;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if ((r == 0 && !vr0) || (r == 2 && !vr2) || (c == 0 && !vc0) ||
					(c == 2 && !vc2)) grid[r][c] = '0;
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					lane_win[i].g[r][c] = grid[r][c][(16-8*i) +: 8];
				end
			end
		end
	end

	logic [sem_pkg::SqW-1:0] mag2 [3];
	logic [2:0] rbusy, rdone;
	logic [7:0] root [3];
	logic grad_en, root_start;
	logic [1:0] gcnt_q;
	assign grad_en = (state_q == ST_GRAD);
	assign root_start = grad_en && gcnt_q == 2'd2;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		sem_grad u_grad (.clk(clk), .en(grad_en), .win(lane_win[i]), .mag2_s2(mag2[i]));
		sem_root u_root (.clk(clk), .arst_n(arst_n), .start(root_start), .m(mag2[i]),
			.busy(rbusy[i]), .done(rdone[i]), .root(root[i]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			w_q <= sem_pkg::DimW'(640);
			h_q <= sem_pkg::DimW'(480);
			col_q <= '0;
			row_q <= '0;
			emitted_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			out_valid <= 1'b0;
			gcnt_q <= '0;
			emit_q <= 1'b0;
			last_q <= 1'b0;
			for (int k = 0; k < 6; k++) win_q[k] <= '0;
		end else begin
			if (out_acc) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						unique case (cfg_index)
							sem_pkg::REG_WIDTH:
								w_q <= sem_pkg::clamp_dim(cfg_data, sem_pkg::MaxWidth);
							sem_pkg::REG_HEIGHT:
								h_q <= sem_pkg::clamp_dim(cfg_data, sem_pkg::MaxHeight);
							default: ;
						endcase
						col_q <= '0;
						row_q <= '0;
						emitted_q <= '0;
						ocol_q <= '0;
						orow_q <= '0;
						for (int k = 0; k < 6; k++) win_q[k] <= '0;
					end else if (in_acc && take) begin
						emit_q <= emit;
						last_q <= emitted_q + 1'b1 >= total;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					gcnt_q <= '0;
					state_q <= emit_q ? ST_GRAD : ST_OUT;
				end
				ST_GRAD: begin
					gcnt_q <= gcnt_q + 1'b1;
					if (gcnt_q == 2'd2) state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					// done is a single pulse; the roots hold until the next start
					if (rdone[0]) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || out_acc) begin
						// advance window and position
						win_q[0] <= win_q[3];
						win_q[1] <= win_q[4];
						win_q[2] <= win_q[5];
						win_q[3] <= up_rd_q;
						win_q[4] <= mid_rd_q;
						win_q[5] <= px_q;
						if (col_q + 1'b1 >= w_q) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else col_q <= col_q + 1'b1;
						if (emit_q) begin
							out_valid <= 1'b1;
							out_red <= root[0];
							out_green <= root[1];
							out_blue <= root[2];
							frame_last <= last_q;
							emitted_q <= emitted_q + 1'b1;
							if (ocol_q + 1'b1 >= sem_pkg::CntW'(w_q)) begin
								ocol_q <= '0;
								orow_q <= orow_q + 1'b1;
							end else ocol_q <= ocol_q + 1'b1;
							if (last_q) begin
								col_q <= '0;
								row_q <= '0;
								emitted_q <= '0;
								ocol_q <= '0;
								orow_q <= '0;
								for (int k = 0; k < 6; k++) win_q[k] <= '0;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// root lanes start and finish together
	assert property (@(posedge clk) disable iff (!arst_n)
		rdone[0] |-> (rdone[1] && rdone[2])) else $error("root lanes out of step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT) |-> (rbusy != '0 || rdone[0] || out_valid))
		else $error("root state without busy lanes");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && emit_q && last_q && (!out_valid || out_acc)) |=>
		(emitted_q == '0 && col_q == '0 && row_q == '0))
		else $error("frame not restarted after last");
endmodule
